### hw/rtl/fpfa_pkg.sv
// Shared types, constants and saturation helpers for the prologue frame analyzer.
// No dependencies; every other file of the block imports this package.
package fpfa_pkg;

  // Field widths.
  localparam int INSN_W    = 32;
  localparam int FRAME_W   = 21;
  localparam int SLOT_W    = 19;
  localparam int VERDICT_W = 2;
  localparam int REG_W     = 5;
  localparam int IMM_W     = 16;
  localparam int SUM_W     = 22;

  // Register numbers.
  localparam logic [REG_W-1:0] SP_REG   = 5'd29;
  localparam logic [REG_W-1:0] RA_REG   = 5'd31;
  localparam logic [REG_W-1:0] ZERO_REG = 5'd0;

  // Opcodes and function codes.
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_DADDIU  = 6'd25;
  localparam logic [5:0] OP_SW      = 6'd43;
  localparam logic [5:0] OP_SD      = 6'd63;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_ADDU    = 6'h21;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_NESTED = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_LEAF   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BOGUS  = 2'd2;

  // Saturation limits.
  localparam logic signed [SUM_W-1:0] FRAME_MAX = 22'sd1048575;
  localparam logic signed [SUM_W-1:0] FRAME_MIN = -22'sd1048576;
  localparam logic signed [SUM_W-1:0] SLOT_MAX  = 22'sd262143;
  localparam logic signed [SUM_W-1:0] SLOT_MIN  = -22'sd262144;
  localparam logic signed [SLOT_W-1:0] SLOT_NONE = -19'sd1;

  // Queue between decode and execute.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // One decoded instruction word.
  typedef struct packed {
    logic                     start;
    logic                     last;
    logic                     is_call;
    logic                     is_adjust;
    logic                     is_copy;
    logic                     is_ra_save;
    logic                     is_addu_sp;
    logic                     rs_zero;
    logic                     rt_zero;
    logic [REG_W-1:0]         rs;
    logic [REG_W-1:0]         rt;
    logic [REG_W-1:0]         rd;
    logic signed [IMM_W-1:0]  imm;
    logic signed [SLOT_W-1:0] slot_quot;
  } cmd_t;

  // Scan state captured at the end of a function.
  typedef struct packed {
    logic signed [FRAME_W-1:0] frame;
    logic signed [FRAME_W-1:0] extra;
    logic signed [SLOT_W-1:0]  slot;
    logic                      slot_valid;
  } snap_t;

  function automatic logic signed [FRAME_W-1:0] sat_frame(input logic signed [SUM_W-1:0] v);
    logic signed [FRAME_W-1:0] r;
    if (v > FRAME_MAX) begin
      r = FRAME_MAX[FRAME_W-1:0];
    end else if (v < FRAME_MIN) begin
      r = FRAME_MIN[FRAME_W-1:0];
    end else begin
      r = v[FRAME_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SLOT_W-1:0] sat_slot(input logic signed [SUM_W-1:0] v);
    logic signed [SLOT_W-1:0] r;
    if (v > SLOT_MAX) begin
      r = SLOT_MAX[SLOT_W-1:0];
    end else if (v < SLOT_MIN) begin
      r = SLOT_MIN[SLOT_W-1:0];
    end else begin
      r = v[SLOT_W-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/fpfa_in_if.sv
// Input channel of the prologue frame analyzer: one instruction word per beat.
// Depends on fpfa_pkg.
interface fpfa_in_if;
  import fpfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [INSN_W-1:0] instruction;
  logic              starts_function;
  logic              is_last;

  modport source(output valid, instruction, starts_function, is_last, input ready);
  modport sink(input valid, instruction, starts_function, is_last, output ready);
endinterface

### hw/rtl/fpfa_out_if.sv
// Result channel of the prologue frame analyzer: one report per beat.
// Depends on fpfa_pkg.
interface fpfa_out_if;
  import fpfa_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [VERDICT_W-1:0]        verdict;
  logic signed [FRAME_W-1:0]   frame_bytes;
  logic signed [SLOT_W-1:0]    return_slot;

  modport source(output valid, verdict, frame_bytes, return_slot, input ready);
  modport sink(input valid, verdict, frame_bytes, return_slot, output ready);
endinterface

### hw/rtl/fpfa_front.sv
// Decode stage: accepts instruction beats, classifies each word and divides
// its offset by the word size. Depends on fpfa_pkg and fpfa_in_if.
module fpfa_front #(
  parameter int WORD_BYTES = 4
) (
  input  logic           clk,
  input  logic           rst,
  fpfa_in_if.sink        insn,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output fpfa_pkg::cmd_t cmd
);
  import fpfa_pkg::*;

  // Reciprocal for a truncating divide of a 16-bit magnitude by WORD_BYTES.
  localparam int DIV_L  = $clog2(WORD_BYTES);
  localparam int DIV_S  = IMM_W + DIV_L;
  localparam int PROD_W = DIV_S + IMM_W;
  localparam longint unsigned DIV_M = ((64'd1 << DIV_S) + WORD_BYTES - 1) / WORD_BYTES;

  logic [5:0]        op;
  logic [5:0]        fn;
  logic [REG_W-1:0]  rs;
  logic [REG_W-1:0]  rt;
  logic [REG_W-1:0]  rd;
  logic signed [IMM_W-1:0] imm;
  logic [IMM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [IMM_W-1:0]  quot;
  logic              is_addu;
  logic              accept;
  cmd_t              cmd_next;

  // Field extraction.
  assign op  = insn.instruction[31:26];
  assign rs  = insn.instruction[25:21];
  assign rt  = insn.instruction[20:16];
  assign rd  = insn.instruction[15:11];
  assign fn  = insn.instruction[5:0];
  assign imm = signed'(insn.instruction[IMM_W-1:0]);
  assign is_addu = (op == OP_SPECIAL) && (fn == FN_ADDU);

  // Offset divided by the word size, truncated toward zero.
  assign mag  = imm[IMM_W-1] ? IMM_W'(-imm) : IMM_W'(imm);
  assign prod = PROD_W'(mag) * PROD_W'(DIV_M);
  assign quot = prod[DIV_S +: IMM_W];

  // Classification of the word.
  always_comb begin
    cmd_next.start      = insn.starts_function;
    cmd_next.last       = insn.is_last;
    cmd_next.is_call    = (op == OP_JAL) ||
                          ((op == OP_SPECIAL) && ((fn == FN_JALR) || (fn == FN_JR)));
    cmd_next.is_adjust  = (rs == SP_REG) && (rt == SP_REG) &&
                          ((op == OP_ADDIU) || (op == OP_DADDIU));
    cmd_next.is_copy    = is_addu && (rd != ZERO_REG) &&
                          (((rt == SP_REG) && (rs == ZERO_REG)) ||
                           ((rt == ZERO_REG) && (rs == SP_REG)));
    cmd_next.is_ra_save = ((op == OP_SW) || (op == OP_SD)) &&
                          (rs == SP_REG) && (rt == RA_REG);
    cmd_next.is_addu_sp = is_addu && (rd == SP_REG);
    cmd_next.rs_zero    = (rs == ZERO_REG);
    cmd_next.rt_zero    = (rt == ZERO_REG);
    cmd_next.rs         = rs;
    cmd_next.rt         = rt;
    cmd_next.rd         = rd;
    cmd_next.imm        = imm;
    cmd_next.slot_quot  = imm[IMM_W-1] ? -signed'(SLOT_W'(quot)) : signed'(SLOT_W'(quot));
  end

  // Output register toward the queue.
  assign insn.ready = !cmd_valid || cmd_ready;
  assign accept     = insn.valid && insn.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

### hw/rtl/fpfa_queue.sv
// Short queue of decoded words between the decode and execute stages.
// Depends on fpfa_pkg.
module fpfa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  fpfa_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fpfa_pkg::cmd_t pop_data
);
  import fpfa_pkg::*;

  cmd_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### hw/rtl/fpfa_back.sv
// Execute stage: applies each decoded word to the scan state and captures the
// state when a function's scan ends. Depends on fpfa_pkg.
module fpfa_back #(
  parameter int WORD_LIMIT = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  fpfa_pkg::cmd_t  cmd,
  output logic            snap_valid,
  input  logic            snap_ready,
  output fpfa_pkg::snap_t snap
);
  import fpfa_pkg::*;

  localparam int CNT_W = $clog2(WORD_LIMIT + 1);

  // Scan state.
  logic signed [FRAME_W-1:0] frame_base;
  logic signed [SLOT_W-1:0]  slot;
  logic                      slot_valid;
  logic [REG_W-1:0]          sp_copy;
  logic signed [FRAME_W-1:0] extra_offset;
  logic [CNT_W-1:0]          word_count;
  logic                      finished;

  logic signed [FRAME_W-1:0] frame_base_next;
  logic signed [SLOT_W-1:0]  slot_next;
  logic                      slot_valid_next;
  logic [REG_W-1:0]          sp_copy_next;
  logic signed [FRAME_W-1:0] extra_offset_next;
  logic [CNT_W-1:0]          word_count_next;
  logic                      finished_next;
  logic                      stop;
  logic                      active;
  logic                      take;
  logic signed [SUM_W-1:0]   extra_diff;
  logic                      restore;

  assign cmd_ready = !snap_valid || snap_ready;
  assign take      = cmd_valid && cmd_ready;

  // Next state for one word, in the priority order of the scan rules.
  always_comb begin
    frame_base_next   = cmd.start ? '0 : frame_base;
    slot_next         = cmd.start ? SLOT_NONE : slot;
    slot_valid_next   = cmd.start ? 1'b0 : slot_valid;
    sp_copy_next      = cmd.start ? ZERO_REG : sp_copy;
    extra_offset_next = cmd.start ? '0 : extra_offset;
    word_count_next   = cmd.start ? '0 : word_count;
    finished_next     = cmd.start ? 1'b0 : finished;
    active            = !finished_next;
    stop              = 1'b0;
    extra_diff        = SUM_W'(extra_offset_next) - SUM_W'(cmd.imm);
    restore           = ((cmd.rs == sp_copy_next) && cmd.rt_zero) ||
                        ((cmd.rt == sp_copy_next) && cmd.rs_zero);

    if (active) begin
      word_count_next = word_count_next + 1'b1;
      if (cmd.is_call) begin
        stop = 1'b1;
      end else if (frame_base_next == '0) begin
        if (cmd.is_adjust) begin
          frame_base_next = -FRAME_W'(cmd.imm);
        end
      end else if ((sp_copy_next == ZERO_REG) && cmd.is_copy) begin
        sp_copy_next = cmd.rd;
      end else if (!slot_valid_next && cmd.is_ra_save) begin
        slot_next       = cmd.slot_quot;
        slot_valid_next = 1'b1;
        if (sp_copy_next == ZERO_REG) begin
          stop = 1'b1;
        end
      end else if ((sp_copy_next != ZERO_REG) && cmd.is_adjust) begin
        extra_offset_next = sat_frame(extra_diff);
      end else if ((sp_copy_next != ZERO_REG) && cmd.is_addu_sp && restore) begin
        extra_offset_next = '0;
        sp_copy_next      = ZERO_REG;
      end
      if (cmd.last || (word_count_next == CNT_W'(WORD_LIMIT))) begin
        stop = 1'b1;
      end
      if (stop) begin
        finished_next = 1'b1;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base   <= '0;
      slot         <= SLOT_NONE;
      slot_valid   <= 1'b0;
      sp_copy      <= ZERO_REG;
      extra_offset <= '0;
      word_count   <= '0;
      finished     <= 1'b1;
    end else if (take) begin
      frame_base   <= frame_base_next;
      slot         <= slot_next;
      slot_valid   <= slot_valid_next;
      sp_copy      <= sp_copy_next;
      extra_offset <= extra_offset_next;
      word_count   <= word_count_next;
      finished     <= finished_next;
    end
  end

  // Capture of the final state toward the report stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (take && active && stop) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && active && stop) begin
      snap.frame      <= frame_base_next;
      snap.extra      <= extra_offset_next;
      snap.slot       <= slot_next;
      snap.slot_valid <= slot_valid_next;
    end
  end

endmodule

### hw/rtl/fpfa_report.sv
// Report stage: folds the extra sp offset into frame size and slot, saturates,
// picks the verdict and holds the result beat. Depends on fpfa_pkg, fpfa_out_if.
module fpfa_report #(
  parameter int WORD_BYTES = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            snap_valid,
  output logic            snap_ready,
  input  fpfa_pkg::snap_t snap,
  fpfa_out_if.source      report
);
  import fpfa_pkg::*;

  // Reciprocal for a truncating divide of the extra offset by WORD_BYTES.
  localparam int DIV_L  = $clog2(WORD_BYTES);
  localparam int DIV_S  = FRAME_W + DIV_L;
  localparam int PROD_W = DIV_S + FRAME_W;
  localparam longint unsigned DIV_M = ((64'd1 << DIV_S) + WORD_BYTES - 1) / WORD_BYTES;

  logic                      mid_valid;
  logic                      mid_ready;
  logic signed [SUM_W-1:0]   mid_frame_sum;
  logic [PROD_W-1:0]         mid_prod;
  logic                      mid_neg;
  logic signed [SLOT_W-1:0]  mid_slot;
  logic                      mid_slot_valid;

  logic [FRAME_W-1:0]        extra_mag;
  logic [FRAME_W-1:0]        quot;
  logic signed [SUM_W-1:0]   quot_signed;
  logic signed [SUM_W-1:0]   slot_sum;
  logic signed [SLOT_W-1:0]  slot_out;
  logic signed [FRAME_W-1:0] frame_out;
  logic [VERDICT_W-1:0]      verdict_out;

  assign mid_ready  = !report.valid || report.ready;
  assign snap_ready = !mid_valid || mid_ready;
  assign extra_mag  = snap.extra[FRAME_W-1] ? FRAME_W'(-snap.extra) : FRAME_W'(snap.extra);

  // First step: frame sum and the reciprocal product.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (snap_ready) begin
      mid_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      mid_frame_sum  <= SUM_W'(snap.frame) + SUM_W'(snap.extra);
      mid_prod       <= PROD_W'(extra_mag) * PROD_W'(DIV_M);
      mid_neg        <= snap.extra[FRAME_W-1];
      mid_slot       <= snap.slot;
      mid_slot_valid <= snap.slot_valid;
    end
  end

  // Second step: slot sum, saturation and verdict.
  always_comb begin
    quot        = mid_prod[DIV_S +: FRAME_W];
    quot_signed = signed'(SUM_W'(quot));
    if (mid_neg) begin
      quot_signed = -quot_signed;
    end
    slot_sum  = SUM_W'(mid_slot) + quot_signed;
    slot_out  = mid_slot_valid ? sat_slot(slot_sum) : SLOT_NONE;
    frame_out = sat_frame(mid_frame_sum);
    if ((frame_out != '0) && (slot_out >= 0)) begin
      verdict_out = VERDICT_NESTED;
    end else if (slot_out < 0) begin
      verdict_out = VERDICT_LEAF;
    end else begin
      verdict_out = VERDICT_BOGUS;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (mid_ready) begin
      report.valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid) begin
      report.verdict     <= verdict_out;
      report.frame_bytes <= frame_out;
      report.return_slot <= slot_out;
    end
  end

endmodule

### hw/rtl/function_prologue_frame_analyzer_core.sv
// Top level of the prologue frame analyzer: decode, queue, execute and report.
// Depends on fpfa_pkg, fpfa_in_if, fpfa_out_if and the fpfa_* stage modules.
//
// The block takes one instruction word per cycle on insn while the queue has
// room, and returns one report on report when a function's scan ends: at a
// jal, jalr or jr, at an ra save after the sp adjust while no copy of sp is
// held, at the word marked is_last, or at the WORD_LIMIT-th word. Words
// that arrive after a scan has ended and before the next word marked
// starts_function are consumed and dropped. The word that ended the scan
// passes the decode register, a queue entry, the execute capture and the two
// report steps before its report is offered. The execute stage takes one word
// per cycle while its capture is free or being read, so the sustained rate is
// one word per cycle, and a four-entry queue lets decode keep accepting while
// the report side is stalled.
module function_prologue_frame_analyzer_core #(
  parameter int WORD_LIMIT = 128,
  parameter int WORD_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  fpfa_in_if.sink     insn,
  fpfa_out_if.source  report
);
  import fpfa_pkg::*;

  logic  dec_valid;
  logic  dec_ready;
  cmd_t  dec_cmd;
  logic  exe_valid;
  logic  exe_ready;
  cmd_t  exe_cmd;
  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  fpfa_front #(
    .WORD_BYTES(WORD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .insn      (insn),
    .cmd_valid (dec_valid),
    .cmd_ready (dec_ready),
    .cmd       (dec_cmd)
  );

  fpfa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (dec_valid),
    .push_ready (dec_ready),
    .push_data  (dec_cmd),
    .pop_valid  (exe_valid),
    .pop_ready  (exe_ready),
    .pop_data   (exe_cmd)
  );

  fpfa_back #(
    .WORD_LIMIT(WORD_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (exe_valid),
    .cmd_ready  (exe_ready),
    .cmd        (exe_cmd),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  fpfa_report #(
    .WORD_BYTES(WORD_BYTES)
  ) u_report (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .report     (report)
  );

endmodule

### hw/rtl/fpfa_checker.sv
// Port-level checks for the prologue frame analyzer, bound to the top level.
// Depends on fpfa_pkg and function_prologue_frame_analyzer_core.
module fpfa_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [fpfa_pkg::VERDICT_W-1:0]      verdict,
  input logic signed [fpfa_pkg::FRAME_W-1:0] frame_bytes,
  input logic signed [fpfa_pkg::SLOT_W-1:0]  return_slot
);
  import fpfa_pkg::*;

  // A report is leaf exactly when its return slot is negative.
  a_leaf_iff_no_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((return_slot < 0) == (verdict == VERDICT_LEAF)))
    else $error("leaf verdict does not match the return slot");

  // A nested verdict needs a frame and a slot, and those always give nested.
  a_nested_rule: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((verdict == VERDICT_NESTED) ==
                   ((frame_bytes != 0) && (return_slot >= 0))))
    else $error("nested verdict does not match frame and slot");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) &&
      $stable(frame_bytes) && $stable(return_slot))
    else $error("result beat changed while stalled");

  // No result is offered right after reset.
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind function_prologue_frame_analyzer_core fpfa_checker u_fpfa_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (report.valid),
  .out_ready   (report.ready),
  .verdict     (report.verdict),
  .frame_bytes (report.frame_bytes),
  .return_slot (report.return_slot)
);
